/* src/fsd_pkg.sv */
// Shared types, constants and helpers for the flock steering direction block.
// Used by every module under src; depends on nothing.
package fsd_pkg;

  localparam int MAX_NEIGHBORS = 1024;
  localparam int DIR_FRAC_BITS = 14;
  localparam int UNIT_ONE      = 1 << DIR_FRAC_BITS;

  localparam int CNT_W   = 11;
  localparam int POS_W   = 24;
  localparam int VEL_W   = 16;
  localparam int DIR_W   = 16;
  localparam int WGT_W   = 16;
  localparam int DIF_W   = POS_W + 1;
  localparam int D2_W    = 50;
  localparam int RR_W    = 2 * POS_W;
  localparam int SUM_W   = 32;
  localparam int VEC_W   = 40;
  localparam int MAG_W   = 30;
  localparam int SQ_W    = 64;
  localparam int NUM_W   = 48;
  localparam int DEN_W   = 32;
  localparam int MUL_W   = 32;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int STEP_W  = 6;
  localparam int ROOT_STEPS = 32;
  localparam int DQ_SHIFT   = 14;
  localparam int SEP_Q_SHIFT = 9;
  localparam int WGT_FRAC   = 16;
  localparam int WGT_SPAN   = 1 << WGT_FRAC;
  localparam int WGT_EXT_W  = WGT_W + 1;
  localparam int ROUND_HALF = 1 << (WGT_FRAC - 1);

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic [1:0] ACT_BEGIN  = 2'd0;
  localparam logic [1:0] ACT_CAND   = 2'd1;
  localparam logic [1:0] ACT_FINISH = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_HERD_RADIUS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEP_DIST    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COH_WGT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALI_WGT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEP_WGT     = 3'd4;

  typedef struct packed {
    logic [1:0]              action;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic                    has_velocity;
    logic                    is_self;
  } in_item_t;

  typedef struct packed {
    logic [CNT_W-1:0]        herd_count;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
  } out_item_t;

  typedef enum logic [1:0] {K_BEGIN, K_CAND, K_FINISH} kind_t;

  typedef struct packed {
    kind_t                   kind;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic                    has_velocity;
  } q_entry_t;

  typedef enum logic {MOP_UNIT, MOP_WEIGHT} mop_t;

  typedef struct packed {
    logic                    start;
    mop_t                    op;
    logic signed [VEC_W-1:0] vx;
    logic signed [VEC_W-1:0] vy;
    logic [D2_W-1:0]         d2;
    logic [POS_W-1:0]        sep;
  } math_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [DIR_W-1:0] ux;
    logic signed [DIR_W-1:0] uy;
    logic [WGT_W-1:0]        w;
  } math_rsp_t;

  typedef enum logic [1:0] {PART_COH, PART_ALI, PART_SEP} part_t;

  typedef enum logic [3:0] {
    M_IDLE, M_NORM, M_SQX, M_SQY, M_SQS, M_ROOT, M_SETX, M_DIVX,
    M_SETY, M_DIVY, M_FINY, M_SETW, M_WDIV, M_FINW, M_DONE
  } math_state_t;

  typedef enum logic [4:0] {
    B_IDLE, B_DIFF, B_SQX, B_SQY, B_SQZ, B_SQR, B_SQS, B_TEST,
    B_WREQ, B_WWAIT, B_UREQ, B_UWAIT, B_PSX, B_PSY, B_PSE,
    B_NAX, B_NAY, B_COH, B_PREQ, B_PWAIT, B_PMX, B_PMY, B_PME,
    B_FREQ, B_FWAIT, B_EMIT
  } back_state_t;

  function automatic logic [VEC_W-1:0] mag_of(input logic signed [VEC_W-1:0] v);
    return v[VEC_W-1] ? VEC_W'(-v) : VEC_W'(v);
  endfunction

  function automatic logic signed [VEC_W-1:0] apply_sign(input logic [VEC_W-1:0] m,
                                                         input logic neg);
    return neg ? -$signed(m) : $signed(m);
  endfunction

endpackage

/* src/fsd_front.sv */
// Input front end: accepts items and classifies them into queue entries.
// Depends on fsd_pkg; feeds fsd_queue.
module fsd_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  fsd_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              q_push,
  output fsd_pkg::q_entry_t q_entry
);
  import fsd_pkg::*;

  logic keep;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready && keep;

  always_comb begin
    keep                 = 1'b0;
    q_entry.kind         = K_BEGIN;
    q_entry.pos_x        = in_data.pos_x;
    q_entry.pos_y        = in_data.pos_y;
    q_entry.pos_z        = in_data.pos_z;
    q_entry.vel_x        = in_data.vel_x;
    q_entry.vel_y        = in_data.vel_y;
    q_entry.has_velocity = in_data.has_velocity;
    case (in_data.action)
      ACT_BEGIN: begin
        keep         = 1'b1;
        q_entry.kind = K_BEGIN;
      end
      ACT_CAND: begin
        // drop the agent itself
        keep         = !in_data.is_self;
        q_entry.kind = K_CAND;
      end
      ACT_FINISH: begin
        keep         = 1'b1;
        q_entry.kind = K_FINISH;
      end
      default: keep = 1'b0;
    endcase
  end

endmodule

/* src/fsd_queue.sv */
// Short FIFO of classified items between the front end and the back end.
// Depends on fsd_pkg.
module fsd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  fsd_pkg::q_entry_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              pop_valid,
  output fsd_pkg::q_entry_t pop_data
);
  import fsd_pkg::*;

  q_entry_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;
  logic              do_push;
  logic              do_pop;

  assign full      = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

/* src/fsd_math.sv */
// Iterative vector normalizer and separation weight unit: shift normalize,
// bit-pair square root and restoring divider. Depends on fsd_pkg.
module fsd_math (
  input  logic               clk,
  input  logic               rst_n,
  input  fsd_pkg::math_req_t req,
  output fsd_pkg::math_rsp_t rsp
);
  import fsd_pkg::*;

  math_state_t             state_r, state_nxt;
  mop_t                    op_r;
  logic [POS_W-1:0]        sep_r;
  logic                    neg_x_r, neg_y_r;
  logic [VEC_W-1:0]        ax_r, ay_r;
  logic [2*MAG_W-1:0]      prod_r, sq_r;
  logic [SQ_W-1:0]         v_r, root_r;
  logic [STEP_W-1:0]       step_r;
  logic [DEN_W-1:0]        den_r, rem_r;
  logic [NUM_W-1:0]        quo_r;
  logic signed [DIR_W-1:0] ux_r, uy_r;
  logic [WGT_W-1:0]        w_r;

  logic [VEC_W-1:0]        m_big;
  logic                    norm_right, norm_left;
  logic [SQ_W-1:0]         root_bit, root_trial;
  logic                    root_take;
  logic [DEN_W:0]          div_trial, div_diff;
  logic                    div_take;
  logic                    last_step;
  logic [MAG_W-1:0]        mul_a;
  logic [2*MAG_W-1:0]      sq_prod;

  function automatic logic signed [DIR_W-1:0] to_unit(input logic [NUM_W-1:0] q,
                                                      input logic neg);
    logic [DIR_W-1:0] m;
    m = (q > NUM_W'(UNIT_ONE)) ? DIR_W'(UNIT_ONE) : q[DIR_W-1:0];
    return neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [WGT_W-1:0] to_weight(input logic [NUM_W-1:0] q);
    logic [WGT_EXT_W-1:0] diff;
    diff = WGT_EXT_W'(WGT_SPAN) - q[WGT_EXT_W-1:0];
    if (q >= NUM_W'(WGT_SPAN)) return '0;
    else if (q == '0) return '1;
    else return diff[WGT_W-1:0];
  endfunction

  assign m_big      = (ax_r > ay_r) ? ax_r : ay_r;
  assign norm_right = |m_big[VEC_W-1:MAG_W];
  assign norm_left  = !m_big[MAG_W-1];
  assign root_bit   = SQ_W'(1) << {step_r[STEP_W-2:0], 1'b0};
  assign root_trial = root_r + root_bit;
  assign root_take  = (v_r >= root_trial);
  assign div_trial  = {rem_r, quo_r[NUM_W-1]};
  assign div_diff   = div_trial - {1'b0, den_r};
  assign div_take   = (div_trial >= {1'b0, den_r});
  assign last_step  = (step_r == '0);
  assign sq_prod    = mul_a * mul_a;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      M_IDLE: begin
        if (req.start) begin
          if (req.op == MOP_WEIGHT)              state_nxt = M_ROOT;
          else if (req.vx == '0 && req.vy == '0) state_nxt = M_DONE;
          else                                   state_nxt = M_NORM;
        end
      end
      M_NORM:  if (!norm_right && !norm_left) state_nxt = M_SQX;
      M_SQX:   state_nxt = M_SQY;
      M_SQY:   state_nxt = M_SQS;
      M_SQS:   state_nxt = M_ROOT;
      M_ROOT:  if (last_step) state_nxt = (op_r == MOP_WEIGHT) ? M_SETW : M_SETX;
      M_SETX:  state_nxt = M_DIVX;
      M_DIVX:  if (last_step) state_nxt = M_SETY;
      M_SETY:  state_nxt = M_DIVY;
      M_DIVY:  if (last_step) state_nxt = M_FINY;
      M_FINY:  state_nxt = M_DONE;
      M_SETW:  state_nxt = M_WDIV;
      M_WDIV:  if (last_step) state_nxt = M_FINW;
      M_FINW:  state_nxt = M_DONE;
      M_DONE:  state_nxt = M_IDLE;
      default: state_nxt = M_IDLE;
    endcase
  end

  always_comb begin
    rsp.done = 1'b0;
    rsp.ux   = ux_r;
    rsp.uy   = uy_r;
    rsp.w    = w_r;
    mul_a    = ax_r[MAG_W-1:0];
    case (state_r)
      M_SQY:   mul_a = ay_r[MAG_W-1:0];
      M_DONE:  rsp.done = 1'b1;
      default: mul_a = ax_r[MAG_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= M_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    case (state_r)
      M_IDLE: begin
        if (req.start) begin
          op_r    <= req.op;
          sep_r   <= req.sep;
          ax_r    <= mag_of(req.vx);
          ay_r    <= mag_of(req.vy);
          neg_x_r <= req.vx[VEC_W-1];
          neg_y_r <= req.vy[VEC_W-1];
          ux_r    <= '0;
          uy_r    <= '0;
          v_r     <= {req.d2, {DQ_SHIFT{1'b0}}};
          root_r  <= '0;
          step_r  <= STEP_W'(ROOT_STEPS - 1);
        end
      end
      M_NORM: begin
        if (norm_right) begin
          ax_r <= ax_r >> 1;
          ay_r <= ay_r >> 1;
        end else if (norm_left) begin
          ax_r <= ax_r << 1;
          ay_r <= ay_r << 1;
        end
      end
      M_SQX: prod_r <= sq_prod;
      M_SQY: begin
        sq_r   <= prod_r;
        prod_r <= sq_prod;
      end
      M_SQS: begin
        v_r    <= SQ_W'(sq_r) + SQ_W'(prod_r);
        root_r <= '0;
        step_r <= STEP_W'(ROOT_STEPS - 1);
      end
      M_ROOT: begin
        if (root_take) begin
          v_r    <= v_r - root_trial;
          root_r <= (root_r >> 1) + root_bit;
        end else begin
          root_r <= root_r >> 1;
        end
        step_r <= step_r - 1'b1;
      end
      M_SETX: begin
        den_r  <= root_r[DEN_W-1:0];
        rem_r  <= '0;
        quo_r  <= (NUM_W'(ax_r[MAG_W-1:0]) << DIR_FRAC_BITS)
                  + NUM_W'(root_r[DEN_W-1:1]);
        step_r <= STEP_W'(NUM_W - 1);
      end
      M_SETY: begin
        ux_r   <= to_unit(quo_r, neg_x_r);
        rem_r  <= '0;
        quo_r  <= (NUM_W'(ay_r[MAG_W-1:0]) << DIR_FRAC_BITS) + NUM_W'(den_r >> 1);
        step_r <= STEP_W'(NUM_W - 1);
      end
      M_SETW: begin
        den_r  <= DEN_W'(sep_r);
        rem_r  <= '0;
        quo_r  <= NUM_W'(root_r[DEN_W-1:0]) << SEP_Q_SHIFT;
        step_r <= STEP_W'(NUM_W - 1);
      end
      M_DIVX, M_DIVY, M_WDIV: begin
        if (div_take) begin
          rem_r <= div_diff[DEN_W-1:0];
          quo_r <= {quo_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_r <= div_trial[DEN_W-1:0];
          quo_r <= {quo_r[NUM_W-2:0], 1'b0};
        end
        step_r <= step_r - 1'b1;
      end
      M_FINY: uy_r <= to_unit(quo_r, neg_y_r);
      M_FINW: w_r  <= to_weight(quo_r);
      default: ;
    endcase
  end

endmodule

/* src/fsd_back.sv */
// Back end: configuration registers, neighbor accumulators, steering
// sequencer and result register. Depends on fsd_pkg and drives fsd_math.
module fsd_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [fsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fsd_pkg::CFG_DAT_W-1:0]    cfg_wdata,
  input  logic                             q_valid,
  input  fsd_pkg::q_entry_t                q_data,
  output logic                             q_pop,
  output fsd_pkg::math_req_t               mreq,
  input  fsd_pkg::math_rsp_t               mrsp,
  output logic                             out_valid,
  input  logic                             out_ready,
  output fsd_pkg::out_item_t               out_data
);
  import fsd_pkg::*;

  back_state_t             state_r, state_nxt;
  logic [POS_W-1:0]        herd_radius_r, sep_dist_r;
  logic [WGT_W-1:0]        coh_wgt_r, ali_wgt_r, sep_wgt_r;
  logic signed [POS_W-1:0] agent_x_r, agent_y_r, agent_z_r;
  logic signed [VEC_W-1:0] sum_pos_x_r, sum_pos_y_r;
  logic signed [SUM_W-1:0] sum_vel_x_r, sum_vel_y_r, push_x_r, push_y_r;
  logic [CNT_W-1:0]        count_r;
  q_entry_t                cur_r;
  logic signed [DIF_W-1:0] dx_r, dy_r, dz_r;
  logic [D2_W-1:0]         d2_r;
  logic [RR_W-1:0]         rr_r;
  logic [PROD_W-1:0]       prod_r;
  logic [WGT_W-1:0]        w_r;
  logic signed [DIR_W-1:0] ux_r, uy_r;
  logic signed [VEC_W-1:0] fx_r, fy_r, cohx_r, cohy_r;
  part_t                   part_r;
  logic signed [DIR_W-1:0] dir_x_r, dir_y_r;
  logic                    out_valid_r;
  out_item_t               out_data_r;

  logic [MUL_W-1:0]        mul_a, mul_b;
  logic [PROD_W-1:0]       mul_p;
  logic signed [VEC_W-1:0] part_vx, part_vy;
  logic [WGT_W-1:0]        part_wgt;
  logic                    in_range, pushes, out_free;
  logic [VEC_W-1:0]        scaled;

  assign mul_p     = mul_a * mul_b;
  assign in_range  = (d2_r <= D2_W'(rr_r)) && (count_r < CNT_W'(MAX_NEIGHBORS));
  assign pushes    = (d2_r != '0) && (d2_r < D2_W'(prod_r[RR_W-1:0]));
  assign out_free  = !out_valid_r || out_ready;
  assign scaled    = VEC_W'((prod_r + PROD_W'(ROUND_HALF)) >> WGT_FRAC);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    case (part_r)
      PART_COH: begin
        part_vx  = cohx_r;
        part_vy  = cohy_r;
        part_wgt = coh_wgt_r;
      end
      PART_ALI: begin
        part_vx  = VEC_W'(sum_vel_x_r);
        part_vy  = VEC_W'(sum_vel_y_r);
        part_wgt = ali_wgt_r;
      end
      default: begin
        part_vx  = VEC_W'(push_x_r);
        part_vy  = VEC_W'(push_y_r);
        part_wgt = sep_wgt_r;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          case (q_data.kind)
            K_CAND:   state_nxt = B_DIFF;
            K_FINISH: state_nxt = (count_r == '0) ? B_EMIT : B_NAX;
            default:  state_nxt = B_IDLE;
          endcase
        end
      end
      B_DIFF:  state_nxt = B_SQX;
      B_SQX:   state_nxt = B_SQY;
      B_SQY:   state_nxt = B_SQZ;
      B_SQZ:   state_nxt = B_SQR;
      B_SQR:   state_nxt = B_SQS;
      B_SQS:   state_nxt = B_TEST;
      B_TEST:  state_nxt = (in_range && pushes) ? B_WREQ : B_IDLE;
      B_WREQ:  state_nxt = B_WWAIT;
      B_WWAIT: if (mrsp.done) state_nxt = B_UREQ;
      B_UREQ:  state_nxt = B_UWAIT;
      B_UWAIT: if (mrsp.done) state_nxt = B_PSX;
      B_PSX:   state_nxt = B_PSY;
      B_PSY:   state_nxt = B_PSE;
      B_PSE:   state_nxt = B_IDLE;
      B_NAX:   state_nxt = B_NAY;
      B_NAY:   state_nxt = B_COH;
      B_COH:   state_nxt = B_PREQ;
      B_PREQ:  state_nxt = B_PWAIT;
      B_PWAIT: if (mrsp.done) state_nxt = B_PMX;
      B_PMX:   state_nxt = B_PMY;
      B_PMY:   state_nxt = B_PME;
      B_PME:   state_nxt = (part_r == PART_SEP) ? B_FREQ : B_PREQ;
      B_FREQ:  state_nxt = B_FWAIT;
      B_FWAIT: if (mrsp.done) state_nxt = B_EMIT;
      B_EMIT:  if (out_free) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    mreq  = '0;
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      B_IDLE: q_pop = q_valid;
      B_SQX: begin
        mul_a = MUL_W'(mag_of(VEC_W'(dx_r)));
        mul_b = MUL_W'(mag_of(VEC_W'(dx_r)));
      end
      B_SQY: begin
        mul_a = MUL_W'(mag_of(VEC_W'(dy_r)));
        mul_b = MUL_W'(mag_of(VEC_W'(dy_r)));
      end
      B_SQZ: begin
        mul_a = MUL_W'(mag_of(VEC_W'(dz_r)));
        mul_b = MUL_W'(mag_of(VEC_W'(dz_r)));
      end
      B_SQR: begin
        mul_a = MUL_W'(herd_radius_r);
        mul_b = MUL_W'(herd_radius_r);
      end
      B_SQS: begin
        mul_a = MUL_W'(sep_dist_r);
        mul_b = MUL_W'(sep_dist_r);
      end
      B_WREQ: begin
        mreq.start = 1'b1;
        mreq.op    = MOP_WEIGHT;
        mreq.d2    = d2_r;
        mreq.sep   = sep_dist_r;
      end
      B_UREQ: begin
        mreq.start = 1'b1;
        mreq.op    = MOP_UNIT;
        mreq.vx    = VEC_W'(dx_r);
        mreq.vy    = VEC_W'(dy_r);
      end
      B_PSX: begin
        mul_a = MUL_W'(mag_of(VEC_W'(ux_r)));
        mul_b = MUL_W'(w_r);
      end
      B_PSY: begin
        mul_a = MUL_W'(mag_of(VEC_W'(uy_r)));
        mul_b = MUL_W'(w_r);
      end
      B_NAX: begin
        mul_a = MUL_W'(mag_of(VEC_W'(agent_x_r)));
        mul_b = MUL_W'(count_r);
      end
      B_NAY: begin
        mul_a = MUL_W'(mag_of(VEC_W'(agent_y_r)));
        mul_b = MUL_W'(count_r);
      end
      B_PREQ: begin
        mreq.start = 1'b1;
        mreq.op    = MOP_UNIT;
        mreq.vx    = part_vx;
        mreq.vy    = part_vy;
      end
      B_PMX: begin
        mul_a = MUL_W'(mag_of(VEC_W'(ux_r)));
        mul_b = MUL_W'(part_wgt);
      end
      B_PMY: begin
        mul_a = MUL_W'(mag_of(VEC_W'(uy_r)));
        mul_b = MUL_W'(part_wgt);
      end
      B_FREQ: begin
        mreq.start = 1'b1;
        mreq.op    = MOP_UNIT;
        mreq.vx    = fx_r;
        mreq.vy    = fy_r;
      end
      default: q_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= B_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      herd_radius_r <= POS_W'(1000);
      sep_dist_r    <= POS_W'(200);
      coh_wgt_r     <= WGT_W'(256);
      ali_wgt_r     <= WGT_W'(256);
      sep_wgt_r     <= WGT_W'(256);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HERD_RADIUS: herd_radius_r <= cfg_wdata;
        REG_SEP_DIST:    sep_dist_r    <= cfg_wdata;
        REG_COH_WGT:     coh_wgt_r     <= cfg_wdata[WGT_W-1:0];
        REG_ALI_WGT:     ali_wgt_r     <= cfg_wdata[WGT_W-1:0];
        REG_SEP_WGT:     sep_wgt_r     <= cfg_wdata[WGT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      agent_x_r   <= '0;
      agent_y_r   <= '0;
      agent_z_r   <= '0;
      sum_pos_x_r <= '0;
      sum_pos_y_r <= '0;
      sum_vel_x_r <= '0;
      sum_vel_y_r <= '0;
      push_x_r    <= '0;
      push_y_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != B_EMIT) out_valid_r <= 1'b0;
      case (state_r)
        B_IDLE: begin
          if (q_valid && q_data.kind == K_BEGIN) begin
            agent_x_r   <= q_data.pos_x;
            agent_y_r   <= q_data.pos_y;
            agent_z_r   <= q_data.pos_z;
            sum_pos_x_r <= '0;
            sum_pos_y_r <= '0;
            sum_vel_x_r <= '0;
            sum_vel_y_r <= '0;
            push_x_r    <= '0;
            push_y_r    <= '0;
            count_r     <= '0;
          end
        end
        B_TEST: begin
          if (in_range) begin
            count_r     <= count_r + 1'b1;
            sum_pos_x_r <= sum_pos_x_r + VEC_W'($signed(cur_r.pos_x));
            sum_pos_y_r <= sum_pos_y_r + VEC_W'($signed(cur_r.pos_y));
            if (cur_r.has_velocity) begin
              sum_vel_x_r <= sum_vel_x_r + SUM_W'($signed(cur_r.vel_x));
              sum_vel_y_r <= sum_vel_y_r + SUM_W'($signed(cur_r.vel_y));
            end
          end
        end
        B_PSY: push_x_r <= push_x_r + SUM_W'(apply_sign(scaled, ux_r[DIR_W-1]));
        B_PSE: push_y_r <= push_y_r + SUM_W'(apply_sign(scaled, uy_r[DIR_W-1]));
        B_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    case (state_r)
      B_IDLE: begin
        cur_r   <= q_data;
        dir_x_r <= '0;
        dir_y_r <= '0;
      end
      B_DIFF: begin
        dx_r <= DIF_W'(agent_x_r) - DIF_W'($signed(cur_r.pos_x));
        dy_r <= DIF_W'(agent_y_r) - DIF_W'($signed(cur_r.pos_y));
        dz_r <= DIF_W'(agent_z_r) - DIF_W'($signed(cur_r.pos_z));
      end
      B_SQY: d2_r <= prod_r[D2_W-1:0];
      B_SQZ: d2_r <= d2_r + prod_r[D2_W-1:0];
      B_SQR: d2_r <= d2_r + prod_r[D2_W-1:0];
      B_SQS: rr_r <= prod_r[RR_W-1:0];
      B_WWAIT: if (mrsp.done) w_r <= mrsp.w;
      B_UWAIT, B_PWAIT: begin
        if (mrsp.done) begin
          ux_r <= mrsp.ux;
          uy_r <= mrsp.uy;
        end
      end
      B_NAY: cohx_r <= sum_pos_x_r - apply_sign(VEC_W'(prod_r), agent_x_r[POS_W-1]);
      B_COH: begin
        cohy_r <= sum_pos_y_r - apply_sign(VEC_W'(prod_r), agent_y_r[POS_W-1]);
        fx_r   <= '0;
        fy_r   <= '0;
        part_r <= PART_COH;
      end
      B_PMY: fx_r <= fx_r + apply_sign(VEC_W'(prod_r), ux_r[DIR_W-1]);
      B_PME: begin
        fy_r <= fy_r + apply_sign(VEC_W'(prod_r), uy_r[DIR_W-1]);
        case (part_r)
          PART_COH: part_r <= PART_ALI;
          default:  part_r <= PART_SEP;
        endcase
      end
      B_FWAIT: begin
        if (mrsp.done) begin
          dir_x_r <= mrsp.ux;
          dir_y_r <= mrsp.uy;
        end
      end
      B_EMIT: begin
        if (out_free) begin
          out_data_r.herd_count <= count_r;
          out_data_r.dir_x      <= dir_x_r;
          out_data_r.dir_y      <= dir_y_r;
        end
      end
      default: ;
    endcase
  end

endmodule

/* src/flock_steering_direction_core.sv */
// Timing: a begin item is taken in the back end alone; a candidate that pushes also
// runs the square root and divider in fsd_math, 1 bit-pair or 1 quotient bit per
// cycle; a finish item is quicker when a part is zero.
// Throughput: one item at a time in the back end; a 4-entry queue takes input meanwhile.
// Reset: synchronous active-low rst_n clears control, config to defaults, state to zero.
module flock_steering_direction_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  fsd_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output fsd_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [fsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fsd_pkg::CFG_DAT_W-1:0] cfg_wdata
);
  import fsd_pkg::*;

  logic      q_full, q_push, q_valid, q_pop;
  q_entry_t  q_entry, q_data;
  math_req_t mreq;
  math_rsp_t mrsp;

  fsd_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  fsd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_entry),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  fsd_math u_math (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  fsd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .mreq      (mreq),
    .mrsp      (mrsp),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* src/fsd_checker.sv */
// Port-level checks on the result channel of the steering core, bound to
// flock_steering_direction_core. Depends on fsd_pkg.
module fsd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input fsd_pkg::out_item_t out_data
);
  import fsd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed before transfer");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.herd_count <= CNT_W'(MAX_NEIGHBORS))
    else $error("herd count above saturation");

  a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_data.dir_x) <= 16'sd16384)
               && ($signed(out_data.dir_x) >= -16'sd16384)
               && ($signed(out_data.dir_y) <= 16'sd16384)
               && ($signed(out_data.dir_y) >= -16'sd16384))
    else $error("direction outside unit range");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.herd_count == '0 |-> out_data.dir_x == '0 && out_data.dir_y == '0)
    else $error("nonzero direction without neighbors");

endmodule

bind flock_steering_direction_core fsd_checker u_fsd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
